// ----- rtl/fcpc_pkg.sv -----
// Shared types and constants for the fan and climate PWM controller.
// Used by fcpc_step and fan_climate_pwm_controller_top; depends on nothing.
package fcpc_pkg;

	typedef enum logic [1:0] {
		CMD_BYTE  = 2'd0,
		CMD_PULSE = 2'd1,
		CMD_LAMP  = 2'd2,
		CMD_FAN   = 2'd3
	} cmd_t;

	localparam logic [7:0] BYTE_POWER  = 8'h36;
	localparam logic [7:0] BYTE_MODE   = 8'h37;
	localparam logic [7:0] BYTE_SLOWER = 8'h38;
	localparam logic [7:0] BYTE_FASTER = 8'h39;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 8;

	localparam logic [CFG_INDEX_W-1:0] REG_FAN_PERIOD    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_FAN_LEVEL_MAX = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_PULSES_PER_REV = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_HEAT_ON_TICKS = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_HEAT_PERIOD   = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_COOL_ON_TICKS = 3'd5;
	localparam logic [CFG_INDEX_W-1:0] REG_COOL_PERIOD   = 3'd6;

	typedef struct packed {
		logic [3:0] fan_period;
		logic [3:0] fan_level_max;
		logic [7:0] pulses_per_reversal;
		logic [3:0] heat_on_ticks;
		logic [3:0] heat_period;
		logic [3:0] cool_on_ticks;
		logic [3:0] cool_period;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		fan_period:          4'd6,
		fan_level_max:       4'd6,
		pulses_per_reversal: 8'd20,
		heat_on_ticks:       4'd3,
		heat_period:         4'd7,
		cool_on_ticks:       4'd5,
		cool_period:         4'd5
	};

	typedef struct packed {
		logic       enabled;
		logic       cool_mode;
		logic       direction_flag;
		logic       left_pin;
		logic [7:0] pulse_count;
		logic [3:0] lamp_count;
		logic [3:0] fan_count;
		logic [3:0] duty_level;
		logic       fan_out;
		logic       lamp_out;
	} state_t;

	localparam state_t STATE_RESET = '{
		enabled:        1'b0,
		cool_mode:      1'b0,
		direction_flag: 1'b0,
		left_pin:       1'b0,
		pulse_count:    8'd0,
		lamp_count:     4'd0,
		fan_count:      4'd0,
		duty_level:     4'd3,
		fan_out:        1'b0,
		lamp_out:       1'b0
	};

	typedef struct packed {
		logic       fan_drive;
		logic       lamp_drive;
		logic       upper_lamp_select;
		logic       turn_left;
		logic       running;
		logic [3:0] fan_level;
	} result_t;

endpackage

// ----- rtl/fcpc_step.sv -----
// Next-state logic for one event of the fan and climate PWM controller.
// Purely combinational; depends on fcpc_pkg for the state and config types.
module fcpc_step (
	input  fcpc_pkg::state_t  state,
	input  fcpc_pkg::cfg_t    cfg,
	input  logic [1:0]        command,
	input  logic [7:0]        rx_byte,
	output fcpc_pkg::state_t  next_state,
	output fcpc_pkg::result_t result
);

	logic [8:0] pulse_inc;
	logic [4:0] lamp_inc;
	logic [4:0] fan_inc;
	logic [3:0] lamp_on;
	logic [3:0] lamp_period;

	assign pulse_inc   = {1'b0, state.pulse_count} + 9'd1;
	assign lamp_inc    = {1'b0, state.lamp_count} + 5'd1;
	assign fan_inc     = {1'b0, state.fan_count} + 5'd1;
	assign lamp_on     = state.cool_mode ? cfg.cool_on_ticks : cfg.heat_on_ticks;
	assign lamp_period = state.cool_mode ? cfg.cool_period : cfg.heat_period;

	always_comb begin
		next_state = state;
		unique case (fcpc_pkg::cmd_t'(command))
			fcpc_pkg::CMD_BYTE: begin
				priority if (rx_byte == fcpc_pkg::BYTE_POWER) begin
					if (!state.enabled) begin
						next_state.enabled        = 1'b1;
						next_state.direction_flag = 1'b0;
						next_state.pulse_count    = 8'd0;
					end else begin
						next_state.enabled  = 1'b0;
						next_state.fan_out  = 1'b0;
						next_state.lamp_out = 1'b0;
					end
				end else if (rx_byte == fcpc_pkg::BYTE_MODE) begin
					next_state.cool_mode  = ~state.cool_mode;
					next_state.lamp_count = 4'd0;
				end else if (rx_byte == fcpc_pkg::BYTE_SLOWER) begin
					if (state.duty_level > 4'd1) begin
						next_state.duty_level = state.duty_level - 4'd1;
						next_state.fan_count  = 4'd0;
					end
				end else if (rx_byte == fcpc_pkg::BYTE_FASTER) begin
					if (state.duty_level < cfg.fan_level_max) begin
						next_state.duty_level = state.duty_level + 4'd1;
						next_state.fan_count  = 4'd0;
					end
				end else begin
					next_state = state;
				end
			end
			fcpc_pkg::CMD_PULSE: begin
				// The left pin copies the inverted flag before the flag itself toggles.
				if (pulse_inc >= {1'b0, cfg.pulses_per_reversal}) begin
					next_state.pulse_count    = 8'd0;
					next_state.left_pin       = ~state.direction_flag;
					next_state.direction_flag = ~state.direction_flag;
				end else begin
					next_state.pulse_count = pulse_inc[7:0];
				end
			end
			fcpc_pkg::CMD_LAMP: begin
				if (state.enabled) begin
					next_state.lamp_out   = (state.lamp_count < lamp_on);
					next_state.lamp_count = (lamp_inc >= {1'b0, lamp_period}) ?
						4'd0 : lamp_inc[3:0];
				end
			end
			fcpc_pkg::CMD_FAN: begin
				if (state.enabled) begin
					next_state.fan_out   = (state.fan_count < state.duty_level);
					next_state.fan_count = (fan_inc >= {1'b0, cfg.fan_period}) ?
						4'd0 : fan_inc[3:0];
				end
			end
			default: next_state = state;
		endcase
	end

	assign result.fan_drive         = next_state.fan_out;
	assign result.lamp_drive        = next_state.lamp_out;
	assign result.upper_lamp_select = next_state.cool_mode;
	assign result.turn_left         = next_state.left_pin;
	assign result.running           = next_state.enabled;
	assign result.fan_level         = next_state.duty_level;

endmodule

// ----- rtl/fan_climate_pwm_controller_top.sv -----
// Top level of the fan and climate PWM controller: state, configuration
// registers and the result buffer. Depends on fcpc_pkg and fcpc_step.
//
// Usage: each request on the input channel (in_valid, in_stall, command,
// rx_byte) is one event: a command byte, a rotation pulse, a lamp tick or a
// fan tick. Every request produces exactly one result on the output channel
// (out_valid, out_stall and the six output fields), showing the outputs
// after that event. A request is taken when valid is high and stall is low.
// The result is registered, in the output or skid register, at the edge that
// takes the request. Throughput is one request per cycle while the receiver does
// not stall; the combinational state update feeds the output register.
// When the receiver stalls, one further result is held in a skid register;
// in_stall rises only once both the output and skid registers are full, and
// it is driven from a register alone.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at the next
// edge and are meant to be made while no request is outstanding; indexes
// beyond the register list are ignored.
// Reset (arst_n low) loads the default configuration, switches the system
// off, sets the fan level to three and empties the result buffer.
module fan_climate_pwm_controller_top (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [1:0]                          command,
	input  logic [7:0]                          rx_byte,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic                                fan_drive,
	output logic                                lamp_drive,
	output logic                                upper_lamp_select,
	output logic                                turn_left,
	output logic                                running,
	output logic [3:0]                          fan_level,
	input  logic                                cfg_we,
	input  logic [fcpc_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [fcpc_pkg::CFG_DATA_W-1:0]     cfg_data
);

	fcpc_pkg::cfg_t    cfg_q;
	fcpc_pkg::state_t  state_q;
	fcpc_pkg::state_t  next_state;
	fcpc_pkg::result_t step_result;
	fcpc_pkg::result_t out_q;
	fcpc_pkg::result_t skid_q;
	logic              out_valid_q;
	logic              skid_valid_q;
	logic              in_accept;
	logic              out_take;

	assign in_stall  = skid_valid_q;
	assign in_accept = in_valid && !skid_valid_q;
	assign out_take  = out_valid_q && !out_stall;

	fcpc_step u_step (
		.state      (state_q),
		.cfg        (cfg_q),
		.command    (command),
		.rx_byte    (rx_byte),
		.next_state (next_state),
		.result     (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= fcpc_pkg::CFG_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				fcpc_pkg::REG_FAN_PERIOD:     cfg_q.fan_period          <= cfg_data[3:0];
				fcpc_pkg::REG_FAN_LEVEL_MAX:  cfg_q.fan_level_max       <= cfg_data[3:0];
				fcpc_pkg::REG_PULSES_PER_REV: cfg_q.pulses_per_reversal <= cfg_data;
				fcpc_pkg::REG_HEAT_ON_TICKS:  cfg_q.heat_on_ticks       <= cfg_data[3:0];
				fcpc_pkg::REG_HEAT_PERIOD:    cfg_q.heat_period         <= cfg_data[3:0];
				fcpc_pkg::REG_COOL_ON_TICKS:  cfg_q.cool_on_ticks       <= cfg_data[3:0];
				fcpc_pkg::REG_COOL_PERIOD:    cfg_q.cool_period         <= cfg_data[3:0];
				default:                      cfg_q                     <= cfg_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= fcpc_pkg::STATE_RESET;
		end else if (in_accept) begin
			state_q <= next_state;
		end
	end

	// Output register plus one skid entry; the skid drains first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (out_take || !out_valid_q) begin
				if (skid_valid_q) begin
					out_valid_q  <= 1'b1;
					skid_valid_q <= 1'b0;
				end else begin
					out_valid_q <= in_accept;
				end
			end else if (in_accept) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_q <= skid_q;
			end else if (in_accept) begin
				out_q <= step_result;
			end
		end else if (in_accept) begin
			skid_q <= step_result;
		end
	end

	assign out_valid         = out_valid_q;
	assign fan_drive         = out_q.fan_drive;
	assign lamp_drive        = out_q.lamp_drive;
	assign upper_lamp_select = out_q.upper_lamp_select;
	assign turn_left         = out_q.turn_left;
	assign running           = out_q.running;
	assign fan_level         = out_q.fan_level;

`ifndef SYNTHESIS
	a_skid_needs_out: assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid entry held while output register empty");

	a_accept_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> out_valid_q)
		else $error("accepted request produced no result");

	a_duty_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.duty_level != 4'd0)
		else $error("fan duty level reached zero");

	a_off_drives_low: assert property (@(posedge clk) disable iff (!arst_n)
		!state_q.enabled |-> (!state_q.fan_out && !state_q.lamp_out))
		else $error("PWM output high while switched off");

	a_skid_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(skid_valid_q && !out_stall) |=> !skid_valid_q)
		else $error("skid entry not moved on when output taken");
`endif

endmodule

// ----- bench/fan_climate_pwm_controller_top_tb.sv -----
// Self-checking bench for the fan and climate PWM controller top level.
// Needs fcpc_pkg and fan_climate_pwm_controller_top; a built-in panel predictor
// checks every result against a queue of expected outputs.
`timescale 1ns / 100ps

module fan_climate_pwm_controller_top_tb;
	import fcpc_pkg::*;

	localparam int unsigned IDLE_LIMIT = 1000;
	localparam int unsigned N_DIR      = 25;
	localparam int unsigned N_PHASES   = 10;
	localparam int unsigned PHASE_REQS = 115;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] data;
		logic       typed;
		result_t    want;
	} dir_row_t;

	localparam result_t OFF_LEVEL3 = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 4'd3};
	localparam result_t ON_LEVEL3  = '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 4'd3};

	// Rows with typed set carry an expectation written by hand; the rest rely on the predictor.
	localparam dir_row_t DIR_TABLE [N_DIR] = '{
		'{CMD_LAMP,  8'h00,       1'b1, OFF_LEVEL3},
		'{CMD_FAN,   8'hFF,       1'b1, OFF_LEVEL3},
		'{CMD_BYTE,  8'h00,       1'b1, OFF_LEVEL3},
		'{CMD_BYTE,  8'hFF,       1'b1, OFF_LEVEL3},
		'{CMD_BYTE,  BYTE_POWER,  1'b1, ON_LEVEL3},
		'{CMD_LAMP,  8'h00,       1'b1, '{1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 4'd3}},
		'{CMD_FAN,   8'h00,       1'b1, '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 4'd3}},
		'{CMD_FAN,   BYTE_POWER,  1'b0, '0},
		'{CMD_BYTE,  BYTE_FASTER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_FASTER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_FASTER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_FASTER, 1'b0, '0},
		'{CMD_FAN,   8'h5A,       1'b0, '0},
		'{CMD_BYTE,  BYTE_SLOWER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_SLOWER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_SLOWER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_SLOWER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_SLOWER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_SLOWER, 1'b0, '0},
		'{CMD_BYTE,  BYTE_MODE,   1'b0, '0},
		'{CMD_LAMP,  8'hA5,       1'b0, '0},
		'{CMD_PULSE, 8'hFF,       1'b0, '0},
		'{CMD_BYTE,  8'h35,       1'b0, '0},
		'{CMD_BYTE,  BYTE_POWER,  1'b0, '0},
		'{CMD_FAN,   8'h00,       1'b0, '0}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_stall;
	cmd_t                   command = CMD_BYTE;
	logic [7:0]             rx_byte = 8'h00;
	logic                   out_valid;
	logic                   out_stall = 1'b0;
	logic                   fan_drive;
	logic                   lamp_drive;
	logic                   upper_lamp_select;
	logic                   turn_left;
	logic                   running;
	logic [3:0]             fan_level;
	logic                   cfg_we = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;

	state_t      panel;
	cfg_t        panel_cfg;
	result_t     pending_outputs [$];
	result_t     oldest;
	int unsigned mismatch_count = 0;
	int unsigned idle_cycles = 0;
	int unsigned sender_calm = 0;
	int unsigned out_hold = 0;
	int unsigned out_calm = 0;

	fan_climate_pwm_controller_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.rx_byte(rx_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.fan_drive(fan_drive),
		.lamp_drive(lamp_drive),
		.upper_lamp_select(upper_lamp_select),
		.turn_left(turn_left),
		.running(running),
		.fan_level(fan_level),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// Mostly no gap, some short ones, a few long; now and then a calm stretch with none.
	function automatic int unsigned next_gap(inout int unsigned calm);
		int unsigned roll;
		if (calm != 0) begin
			calm = calm - 1;
			return 0;
		end
		roll = $urandom_range(0, 99);
		if (roll < 2)
			calm = $urandom_range(40, 150);
		if (roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Counter step shared by both PWM generators: wraps on reaching or passing the period.
	function automatic logic [3:0] pwm_next(logic [3:0] cnt, logic [3:0] period);
		logic [4:0] nxt;
		nxt = {1'b0, cnt} + 5'd1;
		return (nxt >= {1'b0, period}) ? 4'd0 : nxt[3:0];
	endfunction

	function automatic result_t panel_step(cmd_t cmd, logic [7:0] data);
		logic [8:0] pulse_next;
		logic [3:0] lamp_on, lamp_period;
		result_t    r;
		pulse_next = {1'b0, panel.pulse_count} + 9'd1;
		lamp_on = panel.cool_mode ? panel_cfg.cool_on_ticks : panel_cfg.heat_on_ticks;
		lamp_period = panel.cool_mode ? panel_cfg.cool_period : panel_cfg.heat_period;
		case (cmd)
			CMD_BYTE: begin
				case (data)
					BYTE_POWER: begin
						if (!panel.enabled) begin
							panel.enabled = 1'b1;
							panel.direction_flag = 1'b0;
							panel.pulse_count = 8'd0;
						end else begin
							panel.enabled = 1'b0;
							panel.fan_out = 1'b0;
							panel.lamp_out = 1'b0;
						end
					end
					BYTE_MODE: begin
						panel.cool_mode = ~panel.cool_mode;
						panel.lamp_count = 4'd0;
					end
					BYTE_SLOWER: begin
						if (panel.duty_level > 4'd1) begin
							panel.duty_level = panel.duty_level - 4'd1;
							panel.fan_count = 4'd0;
						end
					end
					BYTE_FASTER: begin
						if (panel.duty_level < panel_cfg.fan_level_max) begin
							panel.duty_level = panel.duty_level + 4'd1;
							panel.fan_count = 4'd0;
						end
					end
					default: ;
				endcase
			end
			CMD_PULSE: begin
				// Rotation pulses are counted whether or not the panel is running.
				if (pulse_next >= {1'b0, panel_cfg.pulses_per_reversal}) begin
					panel.pulse_count = 8'd0;
					panel.left_pin = ~panel.direction_flag;
					panel.direction_flag = ~panel.direction_flag;
				end else begin
					panel.pulse_count = pulse_next[7:0];
				end
			end
			CMD_LAMP: begin
				if (panel.enabled) begin
					panel.lamp_out = panel.lamp_count < lamp_on;
					panel.lamp_count = pwm_next(panel.lamp_count, lamp_period);
				end
			end
			default: begin
				if (panel.enabled) begin
					panel.fan_out = panel.fan_count < panel.duty_level;
					panel.fan_count = pwm_next(panel.fan_count, panel_cfg.fan_period);
				end
			end
		endcase
		r.fan_drive = panel.fan_out;
		r.lamp_drive = panel.lamp_out;
		r.upper_lamp_select = panel.cool_mode;
		r.turn_left = panel.left_pin;
		r.running = panel.enabled;
		r.fan_level = panel.duty_level;
		return r;
	endfunction

	task automatic report_mismatch(string what, int unsigned got, int unsigned want);
		mismatch_count++;
		$display("%0t ns: %s: got %0d, expected %0d", $time, what, got, want);
	endtask

	task automatic send_event(cmd_t cmd, logic [7:0] data, logic typed, result_t typed_want);
		int unsigned gap;
		result_t     predicted;
		gap = next_gap(sender_calm);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		command <= cmd;
		rx_byte <= data;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predicted = panel_step(cmd, data);
		pending_outputs.push_back(typed ? typed_want : predicted);
	endtask

	// Drops the request line and waits for every outstanding result, plus a short margin.
	task automatic settle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_outputs.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FAN_PERIOD:     panel_cfg.fan_period = value[3:0];
			REG_FAN_LEVEL_MAX:  panel_cfg.fan_level_max = value[3:0];
			REG_PULSES_PER_REV: panel_cfg.pulses_per_reversal = value;
			REG_HEAT_ON_TICKS:  panel_cfg.heat_on_ticks = value[3:0];
			REG_HEAT_PERIOD:    panel_cfg.heat_period = value[3:0];
			REG_COOL_ON_TICKS:  panel_cfg.cool_on_ticks = value[3:0];
			REG_COOL_PERIOD:    panel_cfg.cool_period = value[3:0];
			default: ;
		endcase
	endtask

	task automatic set_panel_regs(int unsigned fp, int unsigned lmax, int unsigned ppr,
			int unsigned hon, int unsigned hper, int unsigned con, int unsigned cper);
		write_reg(REG_FAN_PERIOD, 8'(fp));
		write_reg(REG_FAN_LEVEL_MAX, 8'(lmax));
		write_reg(REG_PULSES_PER_REV, 8'(ppr));
		write_reg(REG_HEAT_ON_TICKS, 8'(hon));
		write_reg(REG_HEAT_PERIOD, 8'(hper));
		write_reg(REG_COOL_ON_TICKS, 8'(con));
		write_reg(REG_COOL_PERIOD, 8'(cper));
	endtask

	// Command bytes, mostly ones that do something, mixed with ticks and pulses.
	task automatic random_event(output cmd_t cmd, output logic [7:0] data);
		int unsigned roll;
		roll = $urandom_range(0, 99);
		data = 8'($urandom_range(0, 255));
		if (roll < 40) begin
			cmd = CMD_BYTE;
			roll = $urandom_range(0, 19);
			if (roll < 3)
				data = BYTE_POWER;
			else if (roll < 8)
				data = BYTE_MODE;
			else if (roll < 13)
				data = BYTE_SLOWER;
			else if (roll < 18)
				data = BYTE_FASTER;
		end else if (roll < 55) begin
			cmd = CMD_PULSE;
		end else if (roll < 78) begin
			cmd = CMD_LAMP;
		end else begin
			cmd = CMD_FAN;
		end
	endtask

	always @(negedge clk) begin
		if (out_hold != 0) begin
			out_hold = out_hold - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
			out_hold = next_gap(out_calm);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (pending_outputs.size() == 0) begin
				report_mismatch("result with nothing pending", 1, 0);
			end else begin
				oldest = pending_outputs.pop_front();
				if (fan_drive !== oldest.fan_drive)
					report_mismatch("fan_drive", fan_drive, oldest.fan_drive);
				if (lamp_drive !== oldest.lamp_drive)
					report_mismatch("lamp_drive", lamp_drive, oldest.lamp_drive);
				if (upper_lamp_select !== oldest.upper_lamp_select)
					report_mismatch("upper_lamp_select", upper_lamp_select,
						oldest.upper_lamp_select);
				if (turn_left !== oldest.turn_left)
					report_mismatch("turn_left", turn_left, oldest.turn_left);
				if (running !== oldest.running)
					report_mismatch("running", running, oldest.running);
				if (fan_level !== oldest.fan_level)
					report_mismatch("fan_level", fan_level, oldest.fan_level);
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("fan_climate_pwm_controller_top_tb: errors");
			$finish;
		end
	end

	initial begin
		int unsigned phase;
		int unsigned k;
		cmd_t        cmd;
		logic [7:0]  data;
		panel = '{enabled: 1'b0, cool_mode: 1'b0, direction_flag: 1'b0, left_pin: 1'b0,
			pulse_count: 8'd0, lamp_count: 4'd0, fan_count: 4'd0, duty_level: 4'd3,
			fan_out: 1'b0, lamp_out: 1'b0};
		panel_cfg = '{fan_period: 4'd6, fan_level_max: 4'd6, pulses_per_reversal: 8'd20,
			heat_on_ticks: 4'd3, heat_period: 4'd7, cool_on_ticks: 4'd5, cool_period: 4'd5};
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (k = 0; k < N_DIR; k++)
			send_event(DIR_TABLE[k].cmd, DIR_TABLE[k].data, DIR_TABLE[k].typed,
				DIR_TABLE[k].want);

		for (phase = 0; phase < N_PHASES; phase++) begin
			settle();
			case (phase)
				0: set_panel_regs(15, 15, 255, 15, 15, 15, 15);
				1: begin
					// Push the duty to the top, then drop the maximum well below it.
					for (k = 0; k < 14; k++)
						send_event(CMD_BYTE, BYTE_FASTER, 1'b0, '0);
					settle();
					set_panel_regs(1, 1, 1, 0, 1, 0, 1);
				end
				2: begin
					// Zero periods pin the counters at zero; a zero count reverses on every pulse.
					set_panel_regs(0, 1, 0, $urandom_range(0, 15), 0,
						$urandom_range(0, 15), 0);
				end
				3: set_panel_regs(15, 15, 2, 0, 15, 15, 1);
				default: begin
					set_panel_regs($urandom_range(1, 15), $urandom_range(1, 15),
						($urandom_range(0, 3) == 0) ? $urandom_range(1, 255)
							: $urandom_range(1, 10),
						$urandom_range(0, 15), $urandom_range(1, 15),
						$urandom_range(0, 15), $urandom_range(1, 15));
				end
			endcase
			for (k = 0; k < PHASE_REQS; k++) begin
				if ($urandom_range(0, 79) == 0)
					settle();
				random_event(cmd, data);
				send_event(cmd, data, 1'b0, '0);
			end
		end

		settle();
		repeat (5) @(posedge clk);
		if (mismatch_count == 0)
			$display("fan_climate_pwm_controller_top_tb: clean");
		else
			$display("fan_climate_pwm_controller_top_tb: errors");
		$finish;
	end

endmodule
